// ===== hdl/rca_pkg.sv =====
// Package for the RTC counter/alarm block: transfer types, function codes, register map.
`default_nettype none
package rca_pkg;

   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_ADDR  = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_WRITE = 2'd3
   } func_type;

   typedef struct packed {
      func_type    func;
      logic [7:0]  wdata;
   } req_type;

   typedef struct packed {
      logic [7:0]  rdata;
      logic        wakeup;
   } rsp_type;

   localparam logic [3:0] REG_CAPTURE_LO  = 4'h0;
   localparam logic [3:0] REG_CAPTURE_HI  = 4'h3;
   localparam logic [3:0] REG_CONTROL     = 4'h4;
   localparam logic [3:0] REG_EXT_CONTROL = 4'h5;
   localparam logic [3:0] REG_ALARM_LO    = 4'h8;
   localparam logic [3:0] REG_ALARM_HI    = 4'hB;

   localparam int ALARM_ENABLE_BIT = 3;

endpackage
`default_nettype wire

// ===== hdl/rca_regs.sv =====
// Register file, capture counter and alarm countdown; computes one result per transfer.
`default_nettype none
module rca_regs (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            accept,
   input  wire rca_pkg::req_type item,
   output rca_pkg::rsp_type      result
);

   logic [31:0] capture_ff,  capture_in;
   logic [31:0] alarm_ff,    alarm_in;
   logic [7:0]  control_ff,  control_in;
   logic [7:0]  ext_ctrl_ff, ext_ctrl_in;
   logic [7:0]  address_ff,  address_in;
   logic [31:0] countdown_ff, countdown_in;
   logic        running_ff,  running_in;

   logic [3:0]  sel;
   logic [31:0] cd_dec;
   logic        do_reload;

   assign sel = address_ff[3:0];
   assign cd_dec = (countdown_ff != 32'd0) ? countdown_ff - 32'd1 : 32'd0;

   always_comb begin
      capture_in   = capture_ff;
      alarm_in     = alarm_ff;
      control_in   = control_ff;
      ext_ctrl_in  = ext_ctrl_ff;
      address_in   = address_ff;
      countdown_in = countdown_ff;
      running_in   = running_ff;
      do_reload    = 1'b0;
      result       = '0;

      case (item.func)
         rca_pkg::FUNC_TICK: begin
            capture_in = capture_ff + 32'd1;
            if (running_ff) begin
               countdown_in = cd_dec;
               if (cd_dec == 32'd0) begin
                  result.wakeup = 1'b1;
                  capture_in    = '0;
                  do_reload     = 1'b1;
               end
            end
         end
         rca_pkg::FUNC_ADDR: begin
            address_in = item.wdata;
         end
         rca_pkg::FUNC_READ: begin
            if (sel inside {[rca_pkg::REG_CAPTURE_LO:rca_pkg::REG_CAPTURE_HI]})
               result.rdata = capture_ff[{sel[1:0], 3'b000} +: 8];
            address_in = address_ff + 8'd1;
         end
         rca_pkg::FUNC_WRITE: begin
            if (sel inside {[rca_pkg::REG_CAPTURE_LO:rca_pkg::REG_CAPTURE_HI]}) begin
               capture_in[{sel[1:0], 3'b000} +: 8] = item.wdata;
            end else if (sel == rca_pkg::REG_CONTROL) begin
               control_in = item.wdata;
               do_reload  = 1'b1;
            end else if (sel == rca_pkg::REG_EXT_CONTROL) begin
               ext_ctrl_in = item.wdata;
            end else if (sel inside {[rca_pkg::REG_ALARM_LO:rca_pkg::REG_ALARM_HI]}) begin
               alarm_in[{sel[1:0], 3'b000} +: 8] = item.wdata;
               do_reload = 1'b1;
            end
            address_in = address_ff + 8'd1;
         end
         default: ;
      endcase

      // reload sees the freshly written control and alarm values
      if (do_reload) begin
         if (control_in[rca_pkg::ALARM_ENABLE_BIT] && (alarm_in != 32'd0)) begin
            countdown_in = alarm_in;
            running_in   = 1'b1;
         end else begin
            running_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capture_ff   <= '0;
         alarm_ff     <= '0;
         control_ff   <= '0;
         ext_ctrl_ff  <= '0;
         address_ff   <= '0;
         countdown_ff <= '0;
         running_ff   <= 1'b0;
      end else if (accept) begin
         capture_ff   <= capture_in;
         alarm_ff     <= alarm_in;
         control_ff   <= control_in;
         ext_ctrl_ff  <= ext_ctrl_in;
         address_ff   <= address_in;
         countdown_ff <= countdown_in;
         running_ff   <= running_in;
      end
   end

   a_run_needs_alarm: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> (alarm_ff != 32'd0))
      else $error("countdown running with zero alarm");

   a_run_needs_enable: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> control_ff[rca_pkg::ALARM_ENABLE_BIT])
      else $error("countdown running with alarm disabled");

   a_wake_clears_capture: assert property (@(posedge clock) disable iff (reset)
      (accept && result.wakeup) |=> (capture_ff == 32'd0))
      else $error("capture counter not cleared on wakeup");

   a_wake_only_tick: assert property (@(posedge clock) disable iff (reset)
      result.wakeup |-> (item.func == rca_pkg::FUNC_TICK) && (result.rdata == 8'd0))
      else $error("wakeup on a non-tick transfer");

endmodule
`default_nettype wire

// ===== hdl/rca_out_skid.sv =====
// Output register with skid stage for the result channel.
`default_nettype none
module rca_out_skid (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_push,
   input  wire rca_pkg::rsp_type in_data,
   output logic                  in_full,
   output logic                  out_valid,
   input  wire logic             out_stall,
   output rca_pkg::rsp_type      out_data
);

   logic             main_valid_ff, main_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   rca_pkg::rsp_type main_ff, main_in;
   rca_pkg::rsp_type skid_ff, skid_in;
   logic             pop;

   assign pop       = main_valid_ff && !out_stall;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;
   assign in_full   = skid_valid_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || pop) begin
         main_valid_in = skid_valid_ff || in_push;
         main_in       = skid_valid_ff ? skid_ff : in_data;
         skid_valid_in = 1'b0;
      end else if (in_push) begin
         skid_valid_in = 1'b1;
         skid_in       = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid holds data while output register is empty");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !in_push)
      else $error("transfer pushed into a full skid stage");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && pop) |=> (main_valid_ff && !skid_valid_ff))
      else $error("skid entry lost on drain");

endmodule
`default_nettype wire

// ===== hdl/rtc_counter_alarm_registers.sv =====
// Top level of the RTC counter/alarm block behind an indirect register pair.
//
//   channel | direction | payload            | handshake
//   req     | in        | func, wdata        | req_valid / req_stall
//   rsp     | out       | rdata, wakeup      | rsp_valid / rsp_stall
//
// One transfer per cycle unless req_stall; each request yields one registered response.
// Register state updates at the edge the request is taken; output register plus skid stage.
// req_stall rises only when both output stages are full; it is a registered signal.
// Reset is synchronous: all registers, address, countdown and output stages cleared.
`default_nettype none
module rtc_counter_alarm_registers (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire rca_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rca_pkg::rsp_type      rsp_payload
);

   logic             accept;
   logic             full;
   rca_pkg::rsp_type result;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   rca_regs u_regs (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .item   (req_payload),
      .result (result)
   );

   rca_out_skid u_out (
      .clock     (clock),
      .reset     (reset),
      .in_push   (accept),
      .in_data   (result),
      .in_full   (full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_payload)
   );

endmodule
`default_nettype wire
